### src/pmwv_pkg.sv
// ----------------------------------------------------------------------------
// pmwv_pkg: shared types and constants of the phase-modulation voice mixer
// Widths, request and setting codes, and the controller/datapath command bus.
// ----------------------------------------------------------------------------
package pmwv_pkg;

   localparam int VOICES      = 8;
   localparam int TABLE_SIZE  = 1024;
   localparam int PHASE_SHIFT = 22;

   localparam int VOICE_W = $clog2(VOICES);
   localparam int VCNT_W  = $clog2(VOICES + 1);
   localparam int TIDX_W  = $clog2(TABLE_SIZE);

   localparam logic [1:0] REQ_TABLE = 2'd0;
   localparam logic [1:0] REQ_VOICE = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   localparam logic [1:0] TAB_CAR_A = 2'd0;
   localparam logic [1:0] TAB_CAR_B = 2'd1;
   localparam logic [1:0] TAB_MOD   = 2'd2;

   localparam logic [1:0] SET_STEP  = 2'd0;
   localparam logic [1:0] SET_DEPTH = 2'd1;
   localparam logic [1:0] SET_XFADE = 2'd2;
   localparam logic [1:0] SET_PHASE = 2'd3;

   localparam logic [31:0] MOD_OFFSET = 32'h7FFF_FFFF;

   // controller -> datapath commands
   typedef struct packed {
      logic               wr_table;   // table word write
      logic               wr_voice;   // voice setting write
      logic               clr_acc;    // start of tick
      logic               rd_mod;     // stage 0: modulator read
      logic               mul_mod;    // stage 1: depth multiply
      logic               rd_car;     // stage 2: carrier reads
      logic               mul_car;    // stage 3: blend multiply
      logic               acc;        // stage 4: accumulate, advance phase
      logic               emit;       // saturate and send result
      logic [VOICE_W-1:0] voice;
   } pmwv_cmd_type;

endpackage

### src/pmwv_ctrl.sv
// ----------------------------------------------------------------------------
// pmwv_ctrl: request decode and per-voice sequencer
// Walks each active voice through five datapath steps on a tick.
// ----------------------------------------------------------------------------
module pmwv_ctrl
   import pmwv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_type,
   input  logic [3:0]         active_voices,
   output logic               busy,
   output pmwv_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MOD, ST_MUL, ST_CAR, ST_BLEND, ST_ACC, ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [VOICE_W-1:0] voice_ff, voice_in;
   logic [VCNT_W-1:0]  nvoc_ff, nvoc_in;
   logic               go;

   assign go   = start && !busy;
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      voice_in = voice_ff;
      nvoc_in  = nvoc_ff;
      cmd      = '0;
      cmd.voice = voice_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.wr_table = go && (req_type == REQ_TABLE);
            cmd.wr_voice = go && (req_type == REQ_VOICE);
            if (go && req_type == REQ_TICK) begin
               cmd.clr_acc = 1'b1;
               voice_in    = '0;
               if ({1'b0, active_voices} > 5'(VOICES))
                  nvoc_in = VCNT_W'(VOICES);
               else
                  nvoc_in = VCNT_W'(active_voices);
               state_in = (nvoc_in == '0) ? ST_EMIT : ST_MOD;
            end
         end
         ST_MOD:   begin cmd.rd_mod  = 1'b1; state_in = ST_MUL;   end
         ST_MUL:   begin cmd.mul_mod = 1'b1; state_in = ST_CAR;   end
         ST_CAR:   begin cmd.rd_car  = 1'b1; state_in = ST_BLEND; end
         ST_BLEND: begin cmd.mul_car = 1'b1; state_in = ST_ACC;   end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (VCNT_W'(voice_ff) + 1'b1 == nvoc_ff) begin
               state_in = ST_EMIT;
            end else begin
               voice_in = voice_ff + 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_EMIT: begin cmd.emit = 1'b1; state_in = ST_IDLE; end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         voice_ff <= '0;
         nvoc_ff  <= '0;
      end else begin
         state_ff <= state_in;
         voice_ff <= voice_in;
         nvoc_ff  <= nvoc_in;
      end
   end

endmodule

### src/pmwv_dpath.sv
// ----------------------------------------------------------------------------
// pmwv_dpath: wavetables, voice settings and arithmetic
// Three table memories, voice registers, three multipliers and the accumulator.
// ----------------------------------------------------------------------------
module pmwv_dpath
   import pmwv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  pmwv_cmd_type        cmd,
   input  logic [1:0]          table_sel,
   input  logic [2:0]          voice_sel,
   input  logic [1:0]          setting_sel,
   input  logic [9:0]          table_index,
   input  logic [31:0]         value_word,
   output logic                rsp_valid,
   output logic signed [31:0]  mixed_sample
);

   logic [31:0] car_a_mem [TABLE_SIZE];
   logic [31:0] car_b_mem [TABLE_SIZE];
   logic [31:0] mod_mem   [TABLE_SIZE];

   logic [31:0] phase_ff [VOICES];
   logic [31:0] step_ff  [VOICES];
   logic [31:0] depth_ff [VOICES];
   logic [31:0] xfade_ff [VOICES];

   logic [31:0]        mod_rd_ff, a_rd_ff, b_rd_ff;
   logic [31:0]        x_phase_in;
   logic [63:0]        off_prod_ff;
   logic signed [64:0] pa_ff, pb_ff;
   logic signed [37:0] acc_ff, acc_in;
   logic signed [31:0] mix_ff;
   logic               valid_ff;
   logic [TIDX_W-1:0]  wr_idx, ph_idx, x_idx;
   logic               vsel_ok;
   logic signed [65:0] blend;

   assign wr_idx  = table_index[TIDX_W-1:0];
   assign ph_idx  = phase_ff[cmd.voice][PHASE_SHIFT +: TIDX_W];
   assign x_phase_in = phase_ff[cmd.voice] + off_prod_ff[63:32];
   assign x_idx   = x_phase_in[PHASE_SHIFT +: TIDX_W];
   assign vsel_ok = ({1'b0, voice_sel} < 4'(VOICES));

   // tables: one write port, registered reads
   always_ff @(posedge clock) begin
      if (cmd.wr_table && table_sel == TAB_CAR_A) car_a_mem[wr_idx] <= value_word;
      if (cmd.wr_table && table_sel == TAB_CAR_B) car_b_mem[wr_idx] <= value_word;
      if (cmd.wr_table && table_sel == TAB_MOD)   mod_mem[wr_idx]   <= value_word;
      if (cmd.rd_mod) mod_rd_ff <= mod_mem[ph_idx];
      if (cmd.rd_car) begin
         a_rd_ff <= car_a_mem[x_idx];
         b_rd_ff <= car_b_mem[x_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) begin
            phase_ff[i] <= '0;
            step_ff[i]  <= '0;
            depth_ff[i] <= '0;
            xfade_ff[i] <= '0;
         end
      end else begin
         if (cmd.wr_voice && vsel_ok) begin
            case (setting_sel)
               SET_STEP:  step_ff[voice_sel[VOICE_W-1:0]]  <= value_word;
               SET_DEPTH: depth_ff[voice_sel[VOICE_W-1:0]] <= value_word;
               SET_XFADE: xfade_ff[voice_sel[VOICE_W-1:0]] <= value_word;
               default:   phase_ff[voice_sel[VOICE_W-1:0]] <= value_word;
            endcase
         end
         if (cmd.acc)
            phase_ff[cmd.voice] <= phase_ff[cmd.voice] + step_ff[cmd.voice];
      end
   end

   // arithmetic stages; the offset add wraps at 32 bits before the multiply
   always_ff @(posedge clock) begin
      if (cmd.mul_mod)
         off_prod_ff <= 32'(mod_rd_ff + MOD_OFFSET) * depth_ff[cmd.voice];
      if (cmd.mul_car) begin
         pa_ff <= $signed(a_rd_ff) * $signed({1'b0, ~xfade_ff[cmd.voice]});
         pb_ff <= $signed(b_rd_ff) * $signed({1'b0, xfade_ff[cmd.voice]});
      end
   end

   assign blend = 66'(pa_ff) + 66'(pb_ff);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clr_acc)  acc_in = '0;
      else if (cmd.acc) acc_in = acc_ff + 38'($signed(blend[65:32]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         if (acc_ff > 38'sh0_7FFF_FFFF)       mix_ff <= 32'sh7FFF_FFFF;
         else if (acc_ff < -38'sh0_8000_0000) mix_ff <= 32'sh8000_0000;
         else                                 mix_ff <= acc_ff[31:0];
      end
   end

   assign rsp_valid    = valid_ff;
   assign mixed_sample = mix_ff;

endmodule

### src/phase_mod_wavetable_voice_mixer_core.sv
// ----------------------------------------------------------------------------
// phase_mod_wavetable_voice_mixer_core: phase-modulation wavetable mixer
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_* and pulse start while busy is low. A table
//   write or a voice-setting write gives no result.
//   A sample tick walks the active voices one at a time, five steps per
//   voice (modulator read, depth multiply, carrier reads, blend multiply,
//   accumulate), then saturates the sum. busy stays high meanwhile.
//   The result appears on rsp_mixed_sample with rsp_valid high for exactly
//   one cycle, after the saturate step. A tick walks N voices (N = active
//   voices, capped at 8); the per-voice chain of dependent table reads and
//   multiplies sets how long a tick lasts.
//   csr_wr_en / csr_wr_data write active_voices; write only while idle.
//   Reset clears voice settings, active_voices and the sequencer; table
//   contents are undefined until written. The receiver cannot stall:
//   rsp_valid is a strobe.
// ----------------------------------------------------------------------------
module phase_mod_wavetable_voice_mixer_core
   import pmwv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_req_type,
   input  logic [1:0]         req_table_sel,
   input  logic [2:0]         req_voice_sel,
   input  logic [1:0]         req_setting_sel,
   input  logic [9:0]         req_table_index,
   input  logic [31:0]        req_value_word,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_mixed_sample,
   input  logic               csr_wr_en,
   input  logic [3:0]         csr_wr_data
);

   logic [3:0]   active_voices_ff;
   pmwv_cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset)          active_voices_ff <= '0;
      else if (csr_wr_en) active_voices_ff <= csr_wr_data;
   end

   pmwv_ctrl u_ctrl (
      .clock, .reset, .start,
      .req_type      (req_req_type),
      .active_voices (active_voices_ff),
      .busy, .cmd
   );

   pmwv_dpath u_dpath (
      .clock, .reset, .cmd,
      .table_sel    (req_table_sel),
      .voice_sel    (req_voice_sel),
      .setting_sel  (req_setting_sel),
      .table_index  (req_table_index),
      .value_word   (req_value_word),
      .rsp_valid,
      .mixed_sample (rsp_mixed_sample)
   );

`ifndef SYNTH
   a_valid_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without a tick");
   a_no_start_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !busy) else $error("busy after emit");
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_req_type == REQ_TICK) |=> busy)
      else $error("tick not started");
`endif

endmodule
